>>> sv/salwc_pkg.sv
// Shared constants, types and a helper function of the set-associative LRU write-back cache.
// Used by the tag memory, the line state memory, the replacement logic and the top level.
package salwc_pkg;

    localparam int MAX_SETS  = 64;
    localparam int MAX_WAYS  = 4;
    localparam int ADDR_BITS = 32;

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W = WAY_W;

    // Field widths of the configuration registers.
    localparam int OFS_W      = 4;
    localparam int IDX_W      = 3;
    localparam int WAYS_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    // Wide enough for the largest offset plus index shift.
    localparam int SHIFT_W    = 5;

    localparam int OFS_MAX = 8;
    localparam int IDX_MAX = 6;

    localparam logic [OFS_W-1:0]  OFS_RESET  = OFS_W'(5);
    localparam logic [IDX_W-1:0]  IDX_RESET  = IDX_W'(6);
    localparam logic [WAYS_W-1:0] WAYS_RESET = WAYS_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = CFG_IDX_W'(2);

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
    } t_line_state;

    typedef t_line_state [MAX_WAYS-1:0] t_state_row;
    typedef logic [MAX_WAYS-1:0][ADDR_BITS-1:0] t_tag_row;

    // Effective geometry after clamping the configuration registers.
    typedef struct packed {
        logic [OFS_W-1:0]  ob;
        logic [IDX_W-1:0]  ib;
        logic [WAYS_W-1:0] ways;
    } t_geom;

    // Outcome of one lookup, passed from the replacement logic to the top level.
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic             victim_dirty;
    } t_lookup;

    // Row contents of a set that has never been written: invalid, clean, age equals way.
    function automatic t_state_row reset_row();
        t_state_row row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            row[w].valid = 1'b0;
            row[w].dirty = 1'b0;
            row[w].age   = AGE_W'(w);
        end
        return row;
    endfunction

endpackage

>>> sv/set_assoc_lru_writeback_cache.sv
// Tag and state controller of a set-associative, write-back, write-allocate cache with true
// LRU ages. In the cycle a request is accepted the set is read from the synchronous tag and
// line state memories; in the next cycle the tags are compared and the way is chosen. Once
// the output register is free, ages and flags are updated and written back and the result
// is loaded into the output register; the next request is taken in the following cycle, so
// a new set read always sees the previous write. A new request may be accepted while a
// result still waits to be taken; its lookup then waits until the output register frees.
// No clearing pass is needed after reset: per-set flags make untouched sets read as empty.
// Depends on salwc_pkg, salwc_tag_ram, salwc_state_ram and salwc_repl.
module set_assoc_lru_writeback_cache (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [salwc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [salwc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_operation,
    input  logic [salwc_pkg::ADDR_BITS-1:0]       i_address,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_hit,
    output logic [salwc_pkg::WAY_W-1:0]           o_way_used,
    output logic                                  o_victim_dirty,
    output logic [salwc_pkg::ADDR_BITS-1:0]       o_victim_address
);
    import salwc_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic                 r_state;
    logic [OFS_W-1:0]     r_offset_bits;
    logic [IDX_W-1:0]     r_index_bits;
    logic [WAYS_W-1:0]    r_ways_in_use;
    logic                 r_op;
    logic [ADDR_BITS-1:0] r_tag;
    logic [SET_W-1:0]     r_set;
    logic                 r_out_valid;
    logic                 r_hit;
    logic [WAY_W-1:0]     r_way;
    logic                 r_vdirty;
    logic [ADDR_BITS-1:0] r_vaddr;

    t_geom                geom;
    logic                 accept;
    logic                 advance;
    logic [SHIFT_W-1:0]   tag_shift;
    logic [ADDR_BITS-1:0] set_mask;
    logic [SET_W-1:0]     in_set;
    logic [ADDR_BITS-1:0] in_tag;
    t_tag_row             tag_row;
    t_state_row           state_row;
    t_state_row           new_row;
    t_lookup              res;
    logic [ADDR_BITS-1:0] victim_address;

    // Clamp the configuration to the supported geometry.
    always_comb begin
        geom.ob = (r_offset_bits > OFS_W'(OFS_MAX)) ? OFS_W'(OFS_MAX) : r_offset_bits;
        geom.ib = (r_index_bits > IDX_W'(IDX_MAX)) ? IDX_W'(IDX_MAX) : r_index_bits;
        if (r_ways_in_use == '0) begin
            geom.ways = WAYS_W'(1);
        end else if (r_ways_in_use > WAYS_W'(MAX_WAYS)) begin
            geom.ways = WAYS_W'(MAX_WAYS);
        end else begin
            geom.ways = r_ways_in_use;
        end
    end

    assign tag_shift = SHIFT_W'(geom.ob) + SHIFT_W'(geom.ib);
    assign set_mask  = (ADDR_BITS'(1) << geom.ib) - ADDR_BITS'(1);
    assign in_set    = SET_W'((i_address >> geom.ob) & set_mask);
    assign in_tag    = i_address >> tag_shift;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign advance = (r_state == S_LOOK) && (!r_out_valid || i_ready);

    salwc_tag_ram u_tag_ram (
        .i_clk    (i_clk),
        .i_rd_en  (accept),
        .i_rd_set (in_set),
        .o_rd_row (tag_row),
        .i_wr_en  (advance && !res.hit),
        .i_wr_set (r_set),
        .i_wr_way (res.way),
        .i_wr_tag (r_tag)
    );

    salwc_state_ram u_state_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_set (in_set),
        .o_rd_row (state_row),
        .i_wr_en  (advance),
        .i_wr_set (r_set),
        .i_wr_row (new_row)
    );

    salwc_repl u_repl (
        .i_op             (r_op),
        .i_tag            (r_tag),
        .i_set            (r_set),
        .i_geom           (geom),
        .i_tags           (tag_row),
        .i_state          (state_row),
        .o_state          (new_row),
        .o_res            (res),
        .o_victim_address (victim_address)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= OFS_RESET;
            r_index_bits  <= IDX_RESET;
            r_ways_in_use <= WAYS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[OFS_W-1:0];
                CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data[IDX_W-1:0];
                CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data[WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (advance) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_operation;
            r_tag <= in_tag;
            r_set <= in_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_hit    <= res.hit;
            r_way    <= res.way;
            r_vdirty <= res.victim_dirty;
            r_vaddr  <= victim_address;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_hit            = r_hit;
    assign o_way_used       = r_way;
    assign o_victim_dirty   = r_vdirty;
    assign o_victim_address = r_vaddr;

    a_look_blocks_requests: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> !o_ready)
        else $error("request accepted while a lookup is in progress");

    a_accept_starts_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOOK))
        else $error("accepted request did not start a lookup");

    a_lookup_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_state == S_IDLE) && r_out_valid)
        else $error("finished lookup did not load the result register");

    a_result_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_LOOK))
        else $error("result appeared without a lookup");

    a_victim_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> !(res.hit && res.victim_dirty))
        else $error("dirty victim reported on a hit");
endmodule

>>> sv/salwc_tag_ram.sv
// Tag memory: one row of tags per set, registered read, per-way write.
// Depends on salwc_pkg for the row type and sizes.
module salwc_tag_ram (
    input  logic                             i_clk,
    input  logic                             i_rd_en,
    input  logic [salwc_pkg::SET_W-1:0]      i_rd_set,
    output salwc_pkg::t_tag_row              o_rd_row,
    input  logic                             i_wr_en,
    input  logic [salwc_pkg::SET_W-1:0]      i_wr_set,
    input  logic [salwc_pkg::WAY_W-1:0]      i_wr_way,
    input  logic [salwc_pkg::ADDR_BITS-1:0]  i_wr_tag
);
    import salwc_pkg::*;

    t_tag_row r_mem [MAX_SETS];
    t_tag_row r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_set][i_wr_way] <= i_wr_tag;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_set];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

>>> sv/salwc_state_ram.sv
// Line state memory: valid, dirty and LRU age of every way, one row per set.
// A flag per row marks rows written since reset; others read as the reset row.
// Depends on salwc_pkg.
module salwc_state_ram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [salwc_pkg::SET_W-1:0] i_rd_set,
    output salwc_pkg::t_state_row       o_rd_row,
    input  logic                        i_wr_en,
    input  logic [salwc_pkg::SET_W-1:0] i_wr_set,
    input  salwc_pkg::t_state_row       i_wr_row
);
    import salwc_pkg::*;

    t_state_row          r_mem [MAX_SETS];
    t_state_row          r_rd_row;
    logic                r_rd_init;
    logic [MAX_SETS-1:0] r_written;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_init <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_set] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_init <= r_written[i_rd_set];
            end
        end
    end

    assign o_rd_row = r_rd_init ? r_rd_row : reset_row();

endmodule

>>> sv/salwc_repl.sv
// Hit detection, victim choice, LRU aging and victim address rebuild for one set.
// Purely combinational; depends on salwc_pkg.
module salwc_repl (
    input  logic                             i_op,
    input  logic [salwc_pkg::ADDR_BITS-1:0]  i_tag,
    input  logic [salwc_pkg::SET_W-1:0]      i_set,
    input  salwc_pkg::t_geom                 i_geom,
    input  salwc_pkg::t_tag_row              i_tags,
    input  salwc_pkg::t_state_row            i_state,
    output salwc_pkg::t_state_row            o_state,
    output salwc_pkg::t_lookup               o_res,
    output logic [salwc_pkg::ADDR_BITS-1:0]  o_victim_address
);
    import salwc_pkg::*;

    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             inv_found;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] old_way;
    logic [AGE_W-1:0] old_age;
    logic [WAY_W-1:0] way;
    logic [AGE_W-1:0] cur_age;
    logic             victim_dirty;
    logic [SHIFT_W-1:0] tag_shift;
    t_state_row       row;

    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w < int'(i_geom.ways)) begin
                if (!hit && i_state[w].valid && (i_tags[w] == i_tag)) begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
                if (!inv_found && !i_state[w].valid) begin
                    inv_found = 1'b1;
                    inv_way   = WAY_W'(w);
                end
            end
        end

        // Lowest-numbered way holding the largest age wins ties.
        old_way = '0;
        old_age = i_state[0].age;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (w < int'(i_geom.ways) && i_state[w].age > old_age) begin
                old_age = i_state[w].age;
                old_way = WAY_W'(w);
            end
        end

        if (hit) begin
            way = hit_way;
        end else if (inv_found) begin
            way = inv_way;
        end else begin
            way = old_way;
        end

        victim_dirty = !hit && !inv_found && i_state[old_way].dirty;

        cur_age = i_state[way].age;
        row     = i_state;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w < int'(i_geom.ways) && i_state[w].age < cur_age) begin
                row[w].age = i_state[w].age + AGE_W'(1);
            end
        end
        row[way].age = '0;
        if (hit) begin
            row[way].dirty = i_state[way].dirty | (i_op == OP_WRITE);
        end else begin
            row[way].valid = 1'b1;
            row[way].dirty = (i_op == OP_WRITE);
        end
    end

    assign tag_shift = SHIFT_W'(i_geom.ob) + SHIFT_W'(i_geom.ib);

    assign o_victim_address = victim_dirty
        ? ((i_tags[old_way] << tag_shift) | (ADDR_BITS'(i_set) << i_geom.ob))
        : '0;

    assign o_state            = row;
    assign o_res.hit          = hit;
    assign o_res.way          = way;
    assign o_res.victim_dirty = victim_dirty;

endmodule

>>> bench/set_assoc_lru_writeback_cache_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of set_assoc_lru_writeback_cache: directed table, then random traffic.
// Keeps its own tag, flag and LRU-age copy of the cache. Depends on salwc_pkg and the RTL only.
module set_assoc_lru_writeback_cache_test;
    import salwc_pkg::*;

    localparam int LINES         = MAX_SETS * MAX_WAYS;
    localparam int LIMIT         = 200000;
    localparam int DIRECTED_ROWS = 23;
    localparam int SEGMENTS      = 12;
    localparam int SEG_REQUESTS  = 45;

    typedef struct packed {
        logic                 hit;
        logic [WAY_W-1:0]     way;
        logic                 victim_dirty;
        logic [ADDR_BITS-1:0] victim_address;
    } t_cache_result;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
        logic                  op;
        logic [ADDR_BITS-1:0]  addr;
        logic                  pinned;
        t_cache_result         expected;
    } t_row;

    localparam t_cache_result NO_RESULT = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_operation;
    logic [ADDR_BITS-1:0]  i_address;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_hit;
    logic [WAY_W-1:0]      o_way_used;
    logic                  o_victim_dirty;
    logic [ADDR_BITS-1:0]  o_victim_address;

    // A pinned result travels with its request and replaces the predicted one.
    logic                  pin_valid;
    t_cache_result         pin_result;

    logic [ADDR_BITS-1:0]  shadow_tag   [LINES];
    logic                  shadow_valid [LINES];
    logic                  shadow_dirty [LINES];
    logic [AGE_W-1:0]      shadow_age   [LINES];
    logic [OFS_W-1:0]      geo_ofs;
    logic [IDX_W-1:0]      geo_idx;
    logic [WAYS_W-1:0]     geo_ways;

    t_cache_result pending_results [$];
    int fail_count     = 0;
    int results_seen   = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    t_row directed_rows [DIRECTED_ROWS] = '{
        // Cold misses in the first and last set, then hits on the same blocks.
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_READ,  32'h0000_0000, 1'b1, '{1'b0, 2'd0, 1'b0, 32'h0}},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd0, 1'b0, 32'h0}},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 32'h0000_001F, 1'b1, '{1'b1, 2'd0, 1'b0, 32'h0}},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 32'hFFFF_FFE0, 1'b1, '{1'b1, 2'd0, 1'b0, 32'h0}},
        // Fill set 0, then evict dirty lines on a read miss and on a write miss.
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 32'h0000_0800, 1'b0, NO_RESULT},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_READ,  32'h0000_1000, 1'b0, NO_RESULT},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 32'h0000_1800, 1'b0, NO_RESULT},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_READ,  32'h0000_2000, 1'b0, NO_RESULT},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 32'h0000_2800, 1'b0, NO_RESULT},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_READ,  32'h0000_2800, 1'b0, NO_RESULT},
        // Smallest geometry: one set, one way, whole address as tag.
        '{1'b1, CFG_OFFSET_BITS, 4'd0, OP_READ,  32'h0, 1'b0, NO_RESULT},
        '{1'b1, CFG_INDEX_BITS,  4'd0, OP_READ,  32'h0, 1'b0, NO_RESULT},
        '{1'b1, CFG_WAYS_IN_USE, 4'd1, OP_READ,  32'h0, 1'b0, NO_RESULT},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd0, 1'b0, 32'h0}},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_READ,  32'h0000_0004, 1'b1,
          '{1'b0, 2'd0, 1'b1, 32'hFFFF_FFFF}},
        // Out-of-range values that clamp; the victim address uses the new geometry.
        '{1'b1, CFG_OFFSET_BITS, 4'd15, OP_READ, 32'h0, 1'b0, NO_RESULT},
        '{1'b1, CFG_INDEX_BITS,  4'd7,  OP_READ, 32'h0, 1'b0, NO_RESULT},
        '{1'b1, CFG_WAYS_IN_USE, 4'd0,  OP_READ, 32'h0, 1'b0, NO_RESULT},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{1'b1, CFG_WAYS_IN_USE, 4'd15, OP_READ, 32'h0, 1'b0, NO_RESULT},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_READ,  32'hFFFF_FF00, 1'b0, NO_RESULT},
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_READ,  32'h0000_3F00, 1'b0, NO_RESULT},
        // Set 0 still carries ages left unaged while only one way was in use.
        '{1'b0, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 32'h0000_0000, 1'b0, NO_RESULT}
    };

    set_assoc_lru_writeback_cache dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_address        (i_address),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_hit            (o_hit),
        .o_way_used       (o_way_used),
        .o_victim_dirty   (o_victim_dirty),
        .o_victim_address (o_victim_address)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_ready     <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void make_youngest(input int base, input int ways, input int way);
        logic [AGE_W-1:0] cur;
        cur = shadow_age[base + way];
        for (int w = 0; w < ways; w++) begin
            if (shadow_age[base + w] < cur)
                shadow_age[base + w] = shadow_age[base + w] + 1'b1;
        end
        shadow_age[base + way] = '0;
    endfunction

    function automatic t_cache_result lookup_and_update(input logic op,
                                                        input logic [ADDR_BITS-1:0] addr);
        int ob, ib, ways, set_no, base, way;
        logic [ADDR_BITS-1:0] tag;
        logic [63:0] rebuilt;
        logic hit, found;
        t_cache_result res;
        ob   = (geo_ofs > OFS_MAX) ? OFS_MAX : int'(geo_ofs);
        ib   = (geo_idx > IDX_MAX) ? IDX_MAX : int'(geo_idx);
        ways = int'(geo_ways);
        if (ways < 1) ways = 1;
        if (ways > MAX_WAYS) ways = MAX_WAYS;
        set_no = int'((addr >> ob) & ((32'd1 << ib) - 32'd1)) % MAX_SETS;
        tag    = addr >> (ob + ib);
        base   = set_no * MAX_WAYS;
        res    = '0;
        hit    = 1'b0;
        found  = 1'b0;
        way    = 0;
        for (int w = 0; w < ways; w++) begin
            if (!hit && shadow_valid[base + w] && shadow_tag[base + w] == tag) begin
                hit = 1'b1;
                way = w;
            end
        end
        if (hit) begin
            make_youngest(base, ways, way);
            if (op == OP_WRITE) shadow_dirty[base + way] = 1'b1;
        end else begin
            for (int w = 0; w < ways; w++) begin
                if (!found && !shadow_valid[base + w]) begin
                    found = 1'b1;
                    way   = w;
                end
            end
            if (!found) begin
                // Oldest way; on equal ages the lowest way number wins.
                for (int w = 1; w < ways; w++) begin
                    if (shadow_age[base + w] > shadow_age[base + way]) way = w;
                end
                if (shadow_dirty[base + way]) begin
                    rebuilt = ({32'd0, shadow_tag[base + way]} << (ob + ib)) |
                              (64'(set_no) << ob);
                    res.victim_dirty   = 1'b1;
                    res.victim_address = rebuilt[ADDR_BITS-1:0];
                end
            end
            shadow_tag[base + way]   = tag;
            shadow_valid[base + way] = 1'b1;
            shadow_dirty[base + way] = (op == OP_WRITE);
            make_youngest(base, ways, way);
        end
        res.hit = hit;
        res.way = way[WAY_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_cache_result predicted;
        t_cache_result got;
        if (!i_rst_n) begin
            for (int l = 0; l < LINES; l++) begin
                shadow_tag[l]   = '0;
                shadow_valid[l] = 1'b0;
                shadow_dirty[l] = 1'b0;
                shadow_age[l]   = AGE_W'(l % MAX_WAYS);
            end
            geo_ofs  = OFS_RESET;
            geo_idx  = IDX_RESET;
            geo_ways = WAYS_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OFFSET_BITS: geo_ofs  = i_cfg_data[OFS_W-1:0];
                    CFG_INDEX_BITS:  geo_idx  = i_cfg_data[IDX_W-1:0];
                    CFG_WAYS_IN_USE: geo_ways = i_cfg_data[WAYS_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                predicted = lookup_and_update(i_operation, i_address);
                pending_results.push_back(pin_valid ? pin_result : predicted);
            end
            if (o_valid && i_ready) begin
                got = {o_hit, o_way_used, o_victim_dirty, o_victim_address};
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: hit=%0b way=%0d victim=%0b %h",
                                 got.hit, got.way, got.victim_dirty, got.victim_address);
                end else begin
                    predicted = pending_results.pop_front();
                    if (got.hit !== predicted.hit || got.way !== predicted.way ||
                        got.victim_dirty !== predicted.victim_dirty ||
                        got.victim_address !== predicted.victim_address) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result %0d: expected hit=%0b way=%0d victim=%0b %h,",
                                      " got hit=%0b way=%0d victim=%0b %h"}, results_seen,
                                     predicted.hit, predicted.way, predicted.victim_dirty,
                                     predicted.victim_address, got.hit, got.way,
                                     got.victim_dirty, got.victim_address);
                    end
                end
                results_seen++;
            end
        end
    end

    task automatic issue_access(input logic op, input logic [ADDR_BITS-1:0] addr,
                                input logic pin, input t_cache_result pres);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_address   <= addr;
        pin_valid   <= pin;
        pin_result  <= pres;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Holds off new requests until every outstanding result has been taken.
    // The first edge lets a request accepted just now reach the expected queue.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic program_geometry(input logic [CFG_DATA_W-1:0] ofs,
                                    input logic [CFG_DATA_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] ways);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_OFFSET_BITS;
        i_cfg_data  <= ofs;
        @(posedge i_clk);
        i_cfg_index <= CFG_INDEX_BITS;
        i_cfg_data  <= idx;
        @(posedge i_clk);
        i_cfg_index <= CFG_WAYS_IN_USE;
        i_cfg_data  <= ways;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : watchdog
        while (cycle_count < LIMIT) @(posedge i_clk);
        $display("set_assoc_lru_writeback_cache_test NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] ofs_d, idx_d, ways_d;
        logic [ADDR_BITS-1:0]  tag_pool [6];
        logic [ADDR_BITS-1:0]  addr;
        logic [ADDR_BITS-1:0]  set_mask, ofs_mask;
        int eff_ob, eff_ib;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_operation = OP_READ;
        i_address   = '0;
        pin_valid   = 1'b0;
        pin_result  = NO_RESULT;
        send_idle_pct  = 15;
        recv_stall_pct = 47;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].is_cfg) begin
                if (r == 0 || !directed_rows[r - 1].is_cfg) drain_results();
                i_cfg_we    <= 1'b1;
                i_cfg_index <= directed_rows[r].cfg_index;
                i_cfg_data  <= directed_rows[r].cfg_data;
                @(posedge i_clk);
                if (r == DIRECTED_ROWS - 1 || !directed_rows[r + 1].is_cfg) i_cfg_we <= 1'b0;
            end else begin
                issue_access(directed_rows[r].op, directed_rows[r].addr,
                             directed_rows[r].pinned, directed_rows[r].expected);
            end
        end

        for (int g = 0; g < SEGMENTS; g++) begin
            if (g == SEGMENTS / 3) begin
                send_idle_pct  = 47;
                recv_stall_pct = 15;
            end else if (g == 2 * SEGMENTS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (g)
                0:       {ofs_d, idx_d, ways_d} = {4'd0, 4'd0, 4'd1};
                1:       {ofs_d, idx_d, ways_d} = {4'd8, 4'd6, 4'd4};
                2:       {ofs_d, idx_d, ways_d} = {4'd15, 4'd7, 4'd7};
                3:       {ofs_d, idx_d, ways_d} = {4'd2, 4'd1, 4'd2};
                default: begin
                    ofs_d  = 4'($urandom_range(0, 15));
                    idx_d  = 4'($urandom_range(0, 15));
                    ways_d = 4'($urandom_range(0, 15));
                end
            endcase
            drain_results();
            program_geometry(ofs_d, idx_d, ways_d);
            eff_ob   = (ofs_d > OFS_MAX) ? OFS_MAX : int'(ofs_d);
            eff_ib   = (idx_d[2:0] > IDX_MAX) ? IDX_MAX : int'(idx_d[2:0]);
            set_mask = (32'd1 << eff_ib) - 32'd1;
            ofs_mask = (32'd1 << eff_ob) - 32'd1;
            foreach (tag_pool[t]) tag_pool[t] = $urandom;
            // A few tags over a few sets keep hits, evictions and dirty victims all common.
            for (int n = 0; n < SEG_REQUESTS; n++) begin
                if ($urandom_range(0, 99) < 80)
                    addr = (tag_pool[$urandom_range(0, 5)] << (eff_ob + eff_ib)) |
                           ((32'($urandom_range(0, 3)) & set_mask) << eff_ob) |
                           ($urandom & ofs_mask);
                else
                    addr = $urandom;
                issue_access(1'($urandom_range(0, 1)), addr, 1'b0, NO_RESULT);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("set_assoc_lru_writeback_cache_test OK");
        else
            $display("set_assoc_lru_writeback_cache_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
sv/salwc_pkg.sv
sv/salwc_tag_ram.sv
sv/salwc_state_ram.sv
sv/salwc_repl.sv
sv/set_assoc_lru_writeback_cache.sv
bench/set_assoc_lru_writeback_cache_test.sv
